### hw/rtl/mm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types, constants and helpers of the 32-bit MurmurHash3 stream hasher.
// ----------------------------------------------------------------------------
package mm3_pkg;

   localparam int WORD_W          = 32;
   localparam int CNT_W           = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [WORD_W-1:0] MIX_C1   = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] MIX_C2   = 32'h1b873593;
   localparam logic [WORD_W-1:0] FOLD_ADD = 32'he6546b64;
   localparam logic [WORD_W-1:0] FIN_M1   = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] FIN_M2   = 32'hc2b2ae35;

   localparam logic [CNT_W-1:0]  FULL_BYTES = 3'd4;

   // What the back end does with a mixed word
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FOLD,
      KIND_TAIL
   } kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] mixed;
      kind_type          kind;
      logic [CNT_W-1:0]  byte_add;
      logic              last;
   } entry_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_FIN1,
      BK_FIN2,
      BK_EMIT
   } back_state_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int r);
      return (v << r) | (v >> (WORD_W - r));
   endfunction

endpackage

### hw/rtl/mm3_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_req_if
// Request channel: one message word with its byte count and last flag.
// ----------------------------------------------------------------------------
interface mm3_req_if;
   logic                         valid;
   logic                         ready;
   logic [mm3_pkg::WORD_W-1:0]   data_word;
   logic [mm3_pkg::CNT_W-1:0]    byte_count;
   logic                         is_last;

   modport source (output valid, data_word, byte_count, is_last, input ready);
   modport sink   (input valid, data_word, byte_count, is_last, output ready);
endinterface

### hw/rtl/mm3_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_rsp_if
// Response channel: the finished hash of one message.
// ----------------------------------------------------------------------------
interface mm3_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mm3_pkg::WORD_W-1:0]   hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

### hw/rtl/mm3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_front
// Accepts requests, classifies each word and runs the two-stage word mix.
// ----------------------------------------------------------------------------
module mm3_front (
   input  logic                clock,
   input  logic                reset,
   mm3_req_if.sink             req,
   output mm3_pkg::entry_type  push_entry_o,
   output logic                push_o,
   input  logic                full_i
);
   import mm3_pkg::*;

   logic                s1_v_ff, s1_v_in;
   logic [WORD_W-1:0]   s1_prod_ff;
   kind_type            s1_kind_ff;
   logic [CNT_W-1:0]    s1_bytes_ff;
   logic                s1_last_ff;

   logic                s2_v_ff, s2_v_in;
   entry_type           s2_entry_ff, s2_entry_in;

   logic                s1_ready, s2_ready;
   logic [CNT_W-1:0]    sat_cnt;
   logic [CNT_W-1:0]    bytes_cls;
   kind_type            kind_cls;
   logic [WORD_W-1:0]   masked;
   logic [2*WORD_W-1:0] prod1, prod2;

   assign s2_ready  = !s2_v_ff || !full_i;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req.ready = s1_ready;
   assign push_o       = s2_v_ff && !full_i;
   assign push_entry_o = s2_entry_ff;

   // Classify: non-last words are full blocks, last words saturate at four
   always_comb begin
      sat_cnt = (req.byte_count > FULL_BYTES) ? FULL_BYTES : req.byte_count;
      if (!req.is_last) begin
         sat_cnt = FULL_BYTES;
      end
      bytes_cls = sat_cnt;
      masked    = req.data_word;
      case (sat_cnt)
         3'd0: begin
            kind_cls = KIND_NONE;
            masked   = '0;
         end
         3'd1: begin
            kind_cls = KIND_TAIL;
            masked   = {24'd0, req.data_word[7:0]};
         end
         3'd2: begin
            kind_cls = KIND_TAIL;
            masked   = {16'd0, req.data_word[15:0]};
         end
         3'd3: begin
            kind_cls = KIND_TAIL;
            masked   = {8'd0, req.data_word[23:0]};
         end
         default: begin
            kind_cls = KIND_FOLD;
         end
      endcase
      prod1 = masked * MIX_C1;
   end

   always_comb begin
      prod2                = rotl(s1_prod_ff, 15) * MIX_C2;
      s2_entry_in.mixed    = prod2[WORD_W-1:0];
      s2_entry_in.kind     = s1_kind_ff;
      s2_entry_in.byte_add = s1_bytes_ff;
      s2_entry_in.last     = s1_last_ff;
      s1_v_in = s1_ready ? req.valid : s1_v_ff;
      s2_v_in = s2_ready ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && s1_ready) begin
         s1_prod_ff  <= prod1[WORD_W-1:0];
         s1_kind_ff  <= kind_cls;
         s1_bytes_ff <= bytes_cls;
         s1_last_ff  <= req.is_last;
      end
      if (s1_v_ff && s2_ready) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   a_fold_full: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && s2_entry_ff.kind == KIND_FOLD |-> s2_entry_ff.byte_add == FULL_BYTES)
      else $error("fold entry without four bytes");
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && s2_entry_ff.kind != KIND_FOLD |-> s2_entry_ff.last)
      else $error("short word not marked last");
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && full_i |=> s2_v_ff && $stable(s2_entry_ff))
      else $error("mixed word lost while queue full");

endmodule

### hw/rtl/mm3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_queue
// Short FIFO of mixed words between the front and back ends.
// ----------------------------------------------------------------------------
module mm3_queue #(
   parameter int DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  mm3_pkg::entry_type  push_entry_i,
   output logic                full_o,
   input  logic                pop_i,
   output mm3_pkg::entry_type  head_o,
   output logic                head_valid_o
);
   import mm3_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full_o       = (count_ff == CNT_W'(DEPTH));
   assign head_valid_o = (count_ff != '0);
   assign head_o       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entries_ff[wr_ptr_ff] <= push_entry_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o || pop_i)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> head_valid_o)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

### hw/rtl/mm3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_back
// Folds mixed words into the running hash and finalizes each message.
// ----------------------------------------------------------------------------
module mm3_back (
   input  logic                clock,
   input  logic                reset,
   input  mm3_pkg::entry_type  head_i,
   input  logic                head_valid_i,
   output logic                pop_o,
   mm3_rsp_if.source           rsp
);
   import mm3_pkg::*;

   back_state_type      state_ff, state_in;
   logic [WORD_W-1:0]   hash_ff, hash_in;
   logic [WORD_W-1:0]   total_ff, total_in;
   logic [WORD_W-1:0]   fin_ff, fin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_hash_ff, rsp_hash_in;

   logic [WORD_W-1:0]   fold_r, upd_hash, upd_total, xs;
   logic [2*WORD_W-1:0] prod;
   logic                out_free;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hash_value = rsp_hash_ff;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      total_in     = total_ff;
      fin_in       = fin_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop_o        = 1'b0;
      out_free     = !rsp_valid_ff || rsp.ready;
      xs           = '0;
      prod         = '0;

      fold_r    = rotl(hash_ff ^ head_i.mixed, 13);
      upd_total = total_ff + WORD_W'(head_i.byte_add);
      case (head_i.kind)
         KIND_FOLD: upd_hash = (fold_r << 2) + fold_r + FOLD_ADD;
         KIND_TAIL: upd_hash = hash_ff ^ head_i.mixed;
         default:   upd_hash = hash_ff;
      endcase

      case (state_ff)
         BK_RUN: begin
            if (head_valid_i) begin
               pop_o = 1'b1;
               if (head_i.last) begin
                  fin_in   = upd_hash ^ upd_total;
                  hash_in  = '0;
                  total_in = '0;
                  state_in = BK_FIN1;
               end else begin
                  hash_in  = upd_hash;
                  total_in = upd_total;
               end
            end
         end
         BK_FIN1: begin
            xs       = fin_ff ^ (fin_ff >> 16);
            prod     = xs * FIN_M1;
            fin_in   = prod[WORD_W-1:0];
            state_in = BK_FIN2;
         end
         BK_FIN2: begin
            xs       = fin_ff ^ (fin_ff >> 13);
            prod     = xs * FIN_M2;
            fin_in   = prod[WORD_W-1:0];
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_hash_in  = fin_ff ^ (fin_ff >> 16);
               rsp_valid_in = 1'b1;
               state_in     = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         hash_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop_o && head_i.last |=> state_ff == BK_FIN1 && hash_ff == '0 && total_ff == '0)
      else $error("state not cleared after last word");
   a_fin_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_FIN1 |=> state_ff == BK_FIN2)
      else $error("finalize sequence broken");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EMIT && !rsp_valid_ff |=> rsp_valid_ff && state_ff == BK_RUN)
      else $error("hash not emitted into free output register");
   a_pop_run: assert property (@(posedge clock) disable iff (reset)
      pop_o |-> state_ff == BK_RUN)
      else $error("pop outside accumulate state");

endmodule

### hw/rtl/murmur3_stream_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_stream_hash_unit
// 32-bit MurmurHash3 (seed zero) over a stream of little-endian message words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  req     | in  | req.valid/ready   | data_word[31:0] byte_count[2:0] is_last
//  rsp     | out | rsp.valid/ready   | hash_value[31:0]
//
//  Words stream in at one request per cycle while the queue has room; the
//  word mix is a two-stage multiply pipeline and the fold into the running
//  hash is a registered step. A last word then holds the fold stage through
//  the two finalizer multiplies and the emit, and the emit waits while the
//  output register still holds a hash that has not been accepted.
//  Reset is synchronous and clears all control state and the running hash.
//  A stalled response holds in the output register; requests keep flowing
//  into the mix pipeline and queue until the queue fills.
// ----------------------------------------------------------------------------
module murmur3_stream_hash_unit #(
   parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mm3_req_if.sink    req,
   mm3_rsp_if.source  rsp
);
   import mm3_pkg::*;

   // Front to queue
   entry_type  push_entry;
   logic       push;
   logic       full;

   // Queue to back
   entry_type  head;
   logic       head_valid;
   logic       pop;

   // Accept, classify (full block, tail or empty) and mix each word
   mm3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .push_entry_o (push_entry),
      .push_o       (push),
      .full_i       (full)
   );

   // Decouple the mix pipeline from the serial fold
   mm3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_i       (push),
      .push_entry_i (push_entry),
      .full_o       (full),
      .pop_i        (pop),
      .head_o       (head),
      .head_valid_o (head_valid)
   );

   // Fold into the running hash, finalize on the last word, drive the response
   mm3_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_i       (head),
      .head_valid_i (head_valid),
      .pop_o        (pop),
      .rsp          (rsp)
   );

endmodule
